### src/sparse_triple_transpose_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sparse triple transpose unit
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SPARSE_TRIPLE_TRANSPOSE_UNIT_ASSERT_SVH
`define SPARSE_TRIPLE_TRANSPOSE_UNIT_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg
// Shared widths, register indexes and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 10;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  localparam cfg_idx_t REG_ROW_COUNT    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_COLUMN_COUNT = cfg_idx_t'(1);

  localparam coord_t COLUMN_COUNT_RST = coord_t'(1);

  typedef struct packed {
    logic accept_in;     // input channel open
    logic start_count;   // pass that counts emittable entries
    logic start_select;  // pass that picks the next entry in order
    logic load_out;      // move the picked entry to the output register
    logic finish;        // empty the store for the next matrix
  } cmd_t;

  typedef struct packed {
    logic load_last;     // beat with the last flag accepted
    logic pass_done;
    logic none_eligible;
    logic out_taken;
    logic out_is_last;
  } status_t;

endpackage

### src/stt_in_if.sv
// ---------------------------------------------------------------------------
// stt_in_if
// Input triple channel: valid/ready with one nonzero triple per beat.
// ---------------------------------------------------------------------------
interface stt_in_if;
  logic           valid;
  logic           ready;
  stt_pkg::coord_t entry_row;
  stt_pkg::coord_t entry_column;
  stt_pkg::value_t entry_value;
  logic           last_entry;

  modport source (output valid, entry_row, entry_column, entry_value, last_entry,
                  input ready);
  modport sink   (input valid, entry_row, entry_column, entry_value, last_entry,
                  output ready);
endinterface

### src/stt_out_if.sv
// ---------------------------------------------------------------------------
// stt_out_if
// Result channel: valid/ready with one transposed triple per beat.
// ---------------------------------------------------------------------------
interface stt_out_if;
  logic           valid;
  logic           ready;
  stt_pkg::coord_t out_row;
  stt_pkg::coord_t out_column;
  stt_pkg::value_t out_value;
  logic           out_last;
  logic           overflow;

  modport source (output valid, out_row, out_column, out_value, out_last, overflow,
                  input ready);
  modport sink   (input valid, out_row, out_column, out_value, out_last, overflow,
                  output ready);
endinterface

### src/stt_cfg_if.sv
// ---------------------------------------------------------------------------
// stt_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ---------------------------------------------------------------------------
interface stt_cfg_if;
  logic                valid;
  logic                ready;
  stt_pkg::cfg_idx_t  index;
  stt_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/stt_datapath.sv
// ---------------------------------------------------------------------------
// stt_datapath
// Triple store, scan pipeline, ordered selection and output register.
// ---------------------------------------------------------------------------
`include "sparse_triple_transpose_unit_assert.svh"

module stt_datapath #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  stt_in_if.sink           in_i,
  stt_out_if.source        out_o,
  stt_cfg_if.sink          cfg_i,
  input  stt_pkg::cmd_t    cmd_i,
  output stt_pkg::status_t status_o
);

  localparam int unsigned AW      = $clog2(STORE_DEPTH);
  localparam int unsigned CW      = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CRD_W   = stt_pkg::COORD_W;
  localparam int unsigned ENTRY_W = 2 * stt_pkg::COORD_W + stt_pkg::VALUE_W;
  localparam int unsigned KEY_W   = stt_pkg::COORD_W + AW;

  // configuration
  stt_pkg::coord_t column_count_q, column_count_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    column_count_d = column_count_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        stt_pkg::REG_COLUMN_COUNT: column_count_d = stt_pkg::coord_t'(cfg_i.data);
        stt_pkg::REG_ROW_COUNT:    column_count_d = column_count_q; // no effect on results
        default:                   column_count_d = column_count_q;
      endcase
    end
  end

  // load side
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic          in_acc, full;
  logic [ENTRY_W-1:0] mem [STORE_DEPTH];

  assign in_i.ready = cmd_i.accept_in;
  assign in_acc     = in_i.valid & in_i.ready;
  assign full       = (count_q == CW'(STORE_DEPTH));

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    priority if (cmd_i.finish) begin
      count_d = '0;
      drop_d  = 1'b0;
    end else if (in_acc && !full) begin
      count_d = count_q + CW'(1);
    end else if (in_acc) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !full) begin
      mem[count_q[AW-1:0]] <= {in_i.entry_row, in_i.entry_column, in_i.entry_value};
    end
  end

  // scan pipeline: address, registered read, compare
  logic               scan_act_q, mode_sel_q, rd_vld_q, rd_last_q, done_q;
  logic [AW-1:0]      rd_ptr_q, rd_idx_q;
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_at_end;

  assign rd_at_end = ((CW'(rd_ptr_q) + CW'(1)) == count_q);

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_ptr_q];
    rd_idx_q  <= rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q <= 1'b0;
      mode_sel_q <= 1'b0;
      rd_ptr_q   <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      rd_vld_q  <= scan_act_q;
      rd_last_q <= scan_act_q & rd_at_end;
      done_q    <= rd_vld_q & rd_last_q;
      if (cmd_i.start_count || cmd_i.start_select) begin
        scan_act_q <= 1'b1;
        rd_ptr_q   <= '0;
        mode_sel_q <= cmd_i.start_select;
      end else if (scan_act_q) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
        if (rd_at_end) begin
          scan_act_q <= 1'b0;
        end
      end
    end
  end

  // compare stage
  stt_pkg::coord_t r_row, r_col;
  stt_pkg::value_t r_val;
  logic [KEY_W-1:0] r_key;
  logic             elig, after_prev, better;

  logic [CW-1:0]    elig_cnt_q, emitted_q;
  logic             found_q, first_q;
  logic [KEY_W-1:0] best_key_q, prev_key_q;
  stt_pkg::coord_t  best_row_q;
  stt_pkg::value_t  best_val_q;

  assign r_row      = rd_data_q[ENTRY_W-1 -: CRD_W];
  assign r_col      = rd_data_q[ENTRY_W-CRD_W-1 -: CRD_W];
  assign r_val      = rd_data_q[stt_pkg::VALUE_W-1:0];
  assign r_key      = {r_col, rd_idx_q};
  assign elig       = (r_col != '0) && (r_col <= column_count_q);
  assign after_prev = first_q || (r_key > prev_key_q);
  assign better     = !found_q || (r_key < best_key_q);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && mode_sel_q && elig && after_prev && better) begin
      best_key_q <= r_key;
      best_row_q <= r_row;
      best_val_q <= r_val;
    end
  end

  // output register
  logic            out_vld_q, out_last_q, ovf_q;
  stt_pkg::coord_t out_row_q, out_col_q;
  stt_pkg::value_t out_val_q;
  logic            out_taken;

  assign out_taken = out_vld_q & out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q  <= best_key_q[KEY_W-1 -: CRD_W];
      out_col_q  <= best_row_q;
      out_val_q  <= best_val_q;
      out_last_q <= ((emitted_q + CW'(1)) == elig_cnt_q);
      ovf_q      <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= stt_pkg::COLUMN_COUNT_RST;
      count_q        <= '0;
      drop_q         <= 1'b0;
      elig_cnt_q     <= '0;
      emitted_q      <= '0;
      found_q        <= 1'b0;
      first_q        <= 1'b1;
      prev_key_q     <= '0;
      out_vld_q      <= 1'b0;
    end else begin
      column_count_q <= column_count_d;
      count_q        <= count_d;
      drop_q         <= drop_d;
      if (cmd_i.start_count) begin
        elig_cnt_q <= '0;
      end else if (rd_vld_q && !mode_sel_q && elig) begin
        elig_cnt_q <= elig_cnt_q + CW'(1);
      end
      if (cmd_i.start_select) begin
        found_q <= 1'b0;
      end else if (rd_vld_q && mode_sel_q && elig && after_prev && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_vld_q  <= 1'b1;
        prev_key_q <= best_key_q;
        first_q    <= 1'b0;
        emitted_q  <= emitted_q + CW'(1);
      end else if (out_taken) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        first_q   <= 1'b1;
        emitted_q <= '0;
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_row    = out_row_q;
  assign out_o.out_column = out_col_q;
  assign out_o.out_value  = out_val_q;
  assign out_o.out_last   = out_last_q;
  assign out_o.overflow   = ovf_q;

  assign status_o.load_last     = in_acc & in_i.last_entry;
  assign status_o.pass_done     = done_q;
  assign status_o.none_eligible = (elig_cnt_q == '0);
  assign status_o.out_taken     = out_taken;
  assign status_o.out_is_last   = out_last_q;

  `STT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(STORE_DEPTH), "store count past depth")
  `STT_ASSERT_IMP(a_out_no_scan, out_vld_q, !scan_act_q && !rd_vld_q, "scan while result held")
  `STT_ASSERT_NXT(a_finish_clear, cmd_i.finish, count_q == '0 && !drop_q, "store not emptied")
  `STT_ASSERT_IMP(a_select_found, cmd_i.load_out, found_q, "selection pass found no entry")

endmodule

### src/stt_ctrl.sv
// ---------------------------------------------------------------------------
// stt_ctrl
// Sequencer: load, count pass, one selection pass per result, emit.
// ---------------------------------------------------------------------------
module stt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::status_t status_i,
  output stt_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_COUNT  = 2'd1;
  localparam logic [1:0] S_SELECT = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.accept_in = 1'b1;
        if (status_i.load_last) begin
          cmd_o.start_count = 1'b1;
          state_d           = S_COUNT;
        end
      end
      S_COUNT: begin
        if (status_i.pass_done) begin
          if (status_i.none_eligible) begin
            cmd_o.finish = 1'b1;
            state_d      = S_LOAD;
          end else begin
            cmd_o.start_select = 1'b1;
            state_d            = S_SELECT;
          end
        end
      end
      S_SELECT: begin
        if (status_i.pass_done) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_taken) begin
          if (status_i.out_is_last) begin
            cmd_o.finish = 1'b1;
            state_d      = S_LOAD;
          end else begin
            cmd_o.start_select = 1'b1;
            state_d            = S_SELECT;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/sparse_triple_transpose_unit.sv
// ---------------------------------------------------------------------------
// sparse_triple_transpose_unit
// Loads sparse triples and emits them transposed, ordered by source column.
// ---------------------------------------------------------------------------
// Usage:
//   in_i   : one triple (row, column, value, last) per beat. Loading takes one
//            beat per cycle; ready drops after the beat flagged last until the
//            run has been emitted. Triples past STORE_DEPTH are dropped and the
//            run's results carry overflow.
//   out_o  : transposed triples, ascending by source column, ties in load order,
//            only columns 1..column_count. out_last marks the final beat. A run
//            with nothing to emit sends no beat.
//   cfg_i  : index 0 row_count, index 1 column_count; always ready.
// Sequence: a counting pass over the stored triples, then one selection
//   pass per result over the single store read port and a stay in the
//   output register; in_i reopens once the last result has been taken, or
//   after the counting pass if no triple is eligible.
// Stall: a result sits in the output register until taken; the next pass
//   starts after that. Reset empties the store and sets column_count to 1.
// ---------------------------------------------------------------------------
module sparse_triple_transpose_unit #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o,
  stt_cfg_if.sink   cfg_i
);

  stt_pkg::cmd_t    cmd;
  stt_pkg::status_t status;

  stt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  stt_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
